>>> rtl/core/assert_macros.svh
// Assertion helpers used by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ZCPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zcpm assertion failed");

// Next-cycle implication, checked outside reset.
`define ZCPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zcpm assertion failed");

`endif

>>> rtl/core/zcpm_pkg.sv
package zcpm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 24;
  localparam int STEP_W     = 16;
  localparam int TOL_W      = 8;
  localparam int DROP_W     = SAMPLE_W + 1;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W    = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [STEP_W-1:0]          step_t;
  typedef logic [TOL_W-1:0]           tol_t;
  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic [CFG_ADDR_W-1:0]      cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // Register indexes
  localparam cfg_addr_t REG_MIN_STEP   = CFG_ADDR_W'(0);
  localparam cfg_addr_t REG_PERIOD_TOL = CFG_ADDR_W'(1);

  localparam step_t MIN_STEP_RST   = STEP_W'(410);
  localparam tol_t  PERIOD_TOL_RST = TOL_W'(1);

  // Edge phase codes; the unused fourth code behaves as locked
  localparam phase_t PHASE_NONE   = PHASE_W'(0);
  localparam phase_t PHASE_ONE    = PHASE_W'(1);
  localparam phase_t PHASE_LOCKED = PHASE_W'(2);

endpackage

>>> rtl/core/zcpm_if.sv
interface zcpm_in_if;
  logic               valid;
  logic               ready;
  zcpm_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface zcpm_out_if;
  logic              valid;
  logic              ready;
  logic              edge_seen;
  zcpm_pkg::count_t  period_length;
  zcpm_pkg::count_t  reference_length;
  logic              locked;
  logic              mismatch;
  logic              unstable;

  modport source (output valid, output edge_seen, output period_length,
                  output reference_length, output locked, output mismatch,
                  output unstable, input ready);
  modport sink   (input valid, input edge_seen, input period_length,
                  input reference_length, input locked, input mismatch,
                  input unstable, output ready);
endinterface

>>> rtl/core/zero_crossing_period_monitor.sv
// Channel  | Dir | Handshake        | Beat contents
// in_ch    | in  | valid/ready      | sample
// out_ch   | out | valid/ready      | edge_seen, period_length, reference_length,
//          |     |                  | locked, mismatch, unstable
// cfg_*    | in  | write enable     | cfg_addr selects min_step or period_tolerance
//
// One beat per clock sustained while out_ch.ready is high; a sample is held in
// the input register, then its result is registered in the output registers,
// with the measurement state updated as the sample leaves the input register.
// rst_n is synchronous: it clears the state, both valid flags and restores
// register defaults. A stalled result holds while one more sample waits in
// the input register; in_ch.ready drops only when both are full.
`include "assert_macros.svh"

module zero_crossing_period_monitor (
  input  logic                 clk,
  input  logic                 rst_n,
  zcpm_in_if.sink              in_ch,
  zcpm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  zcpm_pkg::cfg_addr_t  cfg_addr,
  input  zcpm_pkg::cfg_data_t  cfg_wdata
);

  // Configuration
  zcpm_pkg::step_t min_step_r;
  zcpm_pkg::tol_t  period_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r   <= zcpm_pkg::MIN_STEP_RST;
      period_tol_r <= zcpm_pkg::PERIOD_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        zcpm_pkg::REG_MIN_STEP:   min_step_r   <= cfg_wdata[zcpm_pkg::STEP_W-1:0];
        zcpm_pkg::REG_PERIOD_TOL: period_tol_r <= cfg_wdata[zcpm_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic              s1_valid_r;
  zcpm_pkg::sample_t s1_sample_r;
  logic              out_valid_r;
  logic              s1_adv;
  logic              in_fire;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Measurement state
  zcpm_pkg::sample_t prev_r;
  zcpm_pkg::count_t  count_r;
  zcpm_pkg::count_t  ref_r;
  zcpm_pkg::phase_t  phase_r;
  logic              sticky_r;

  zcpm_pkg::count_t  count_nxt;
  zcpm_pkg::count_t  ref_nxt;
  zcpm_pkg::phase_t  phase_nxt;
  logic              sticky_nxt;

  logic                        prev_pos;
  logic                        cur_nonpos;
  logic [zcpm_pkg::DROP_W-1:0] drop;
  logic                        edge_hit;
  logic                        count_gt;
  zcpm_pkg::count_t            diff;
  logic                        mism;
  logic                        locked_nxt;

  always_comb begin
    prev_pos   = !prev_r[zcpm_pkg::SAMPLE_W-1] && (prev_r != '0);
    cur_nonpos = s1_sample_r[zcpm_pkg::SAMPLE_W-1] || (s1_sample_r == '0);
    drop       = {prev_r[zcpm_pkg::SAMPLE_W-1], prev_r}
               - {s1_sample_r[zcpm_pkg::SAMPLE_W-1], s1_sample_r};
    edge_hit   = prev_pos && cur_nonpos && (drop >= zcpm_pkg::DROP_W'(min_step_r));

    count_gt = count_r > ref_r;
    diff     = count_gt ? (count_r - ref_r) : (ref_r - count_r);

    count_nxt  = count_r;
    ref_nxt    = ref_r;
    phase_nxt  = phase_r;
    sticky_nxt = sticky_r;
    mism       = 1'b0;

    if (edge_hit) begin
      case (phase_r)
        zcpm_pkg::PHASE_NONE: phase_nxt = zcpm_pkg::PHASE_ONE;
        zcpm_pkg::PHASE_ONE: begin
          ref_nxt   = count_r;
          phase_nxt = zcpm_pkg::PHASE_LOCKED;
        end
        default: begin
          mism = diff > zcpm_pkg::COUNT_W'(period_tol_r);
          if (mism) sticky_nxt = 1'b1;
        end
      endcase
      count_nxt = zcpm_pkg::COUNT_W'(1);
    end else if (!(&count_r)) begin
      // saturate at all ones
      count_nxt = count_r + zcpm_pkg::COUNT_W'(1);
    end

    locked_nxt = phase_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      count_r     <= '0;
      ref_r       <= '0;
      phase_r     <= zcpm_pkg::PHASE_NONE;
      sticky_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        prev_r   <= s1_sample_r;
        count_r  <= count_nxt;
        ref_r    <= ref_nxt;
        phase_r  <= phase_nxt;
        sticky_r <= sticky_nxt;
      end
    end
  end

  // Payload registers
  logic             edge_seen_r;
  zcpm_pkg::count_t period_len_r;
  zcpm_pkg::count_t ref_len_r;
  logic             locked_r;
  logic             mismatch_r;
  logic             unstable_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_ch.sample;
    end
    if (s1_adv) begin
      edge_seen_r  <= edge_hit;
      period_len_r <= edge_hit ? count_r : '0;
      ref_len_r    <= locked_nxt ? ref_nxt : '0;
      locked_r     <= locked_nxt;
      mismatch_r   <= mism;
      unstable_r   <= sticky_nxt || (phase_nxt == zcpm_pkg::PHASE_NONE);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.edge_seen        = edge_seen_r;
  assign out_ch.period_length    = period_len_r;
  assign out_ch.reference_length = ref_len_r;
  assign out_ch.locked           = locked_r;
  assign out_ch.mismatch         = mismatch_r;
  assign out_ch.unstable         = unstable_r;

  `ZCPM_ASSERT_NOW(a_edge_period_nonzero, clk, rst_n, out_valid_r && edge_seen_r, period_len_r != '0)
  `ZCPM_ASSERT_NOW(a_no_edge_quiet, clk, rst_n, out_valid_r && !edge_seen_r, !mismatch_r && (period_len_r == '0))
  `ZCPM_ASSERT_NOW(a_mismatch_locked, clk, rst_n, out_valid_r && mismatch_r, locked_r && unstable_r)
  `ZCPM_ASSERT_NEXT(a_sticky_holds, clk, rst_n, sticky_r, sticky_r && phase_r[1])

endmodule
